// File: design/pdp_pkg.sv
`timescale 1ns / 1ps

package pdp_pkg;

  localparam int unsigned TimeWidthDefault = 64;
  localparam int unsigned NowWidth         = 64;
  localparam int unsigned IvlWidth         = 30;
  localparam int unsigned OutDataWidth     = 168;
  localparam int unsigned CfgAddrWidth     = 3;
  localparam int unsigned CfgDataWidth     = 32;

  // register index of target_interval_ns
  localparam logic [0:0] RegTargetInterval = 1'b0;

  // tolerance = max(TolFloor, floor(ivl * 3 / 100)); the /100 is a reciprocal multiply
  localparam int unsigned TolWidth   = 26;
  localparam logic [TolWidth-1:0] TolFloor = TolWidth'(250000);
  localparam logic [1:0]  TolPct     = 2'd3;
  localparam int unsigned TolXWidth  = 32;
  localparam int unsigned RecipWidth = 33;
  localparam logic [RecipWidth-1:0] TolRecip = 33'd5497558139;
  localparam int unsigned RecipShift = 39;
  localparam int unsigned ProdWidth  = TolXWidth + RecipWidth;
  localparam int unsigned GapShift   = 2;

  localparam int unsigned StepWidth = 5;

  typedef enum logic [3:0] {
    OpNone,
    OpLoadNow,
    OpClear,
    OpObserve,
    OpTolMul,
    OpTolSet,
    OpFlags,
    OpEarly,
    OpDivInit,
    OpDivStep,
    OpLateSet,
    OpFirst,
    OpBack,
    OpGap,
    OpEmit
  } pdp_op_e;

  typedef enum logic [3:0] {
    CondNever,
    CondAlways,
    CondNoInput,
    CondIvlZero,
    CondFirst,
    CondBackward,
    CondGap,
    CondLate,
    CondDivMore,
    CondOutBusy
  } pdp_cond_e;

  typedef struct packed {
    pdp_op_e                op;
    pdp_cond_e              cond;
    logic [StepWidth-1:0]   target;
  } ucode_t;

  typedef struct packed {
    logic init;
    logic step;
  } div_ctrl_t;

  localparam logic [StepWidth-1:0] StepFetch     = 5'd0;
  localparam logic [StepWidth-1:0] StepCheck     = 5'd1;
  localparam logic [StepWidth-1:0] StepTestFirst = 5'd2;
  localparam logic [StepWidth-1:0] StepTestBack  = 5'd3;
  localparam logic [StepWidth-1:0] StepObserve   = 5'd4;
  localparam logic [StepWidth-1:0] StepTestGap   = 5'd5;
  localparam logic [StepWidth-1:0] StepTolMul    = 5'd6;
  localparam logic [StepWidth-1:0] StepTolSet    = 5'd7;
  localparam logic [StepWidth-1:0] StepFlags     = 5'd8;
  localparam logic [StepWidth-1:0] StepEarly     = 5'd9;
  localparam logic [StepWidth-1:0] StepDivInit   = 5'd10;
  localparam logic [StepWidth-1:0] StepDivStep   = 5'd11;
  localparam logic [StepWidth-1:0] StepLateSet   = 5'd12;
  localparam logic [StepWidth-1:0] StepFirst     = 5'd13;
  localparam logic [StepWidth-1:0] StepBack      = 5'd14;
  localparam logic [StepWidth-1:0] StepGap       = 5'd15;
  localparam logic [StepWidth-1:0] StepEmit      = 5'd16;
  localparam logic [StepWidth-1:0] StepLast      = StepEmit;

  // control store: jump to target when the condition holds, else fall through
  function automatic ucode_t ucode_rom(logic [StepWidth-1:0] pc);
    ucode_t w;
    case (pc)
      StepFetch:     w = '{OpLoadNow, CondNoInput,  StepFetch};
      StepCheck:     w = '{OpClear,   CondIvlZero,  StepEmit};
      StepTestFirst: w = '{OpNone,    CondFirst,    StepFirst};
      StepTestBack:  w = '{OpNone,    CondBackward, StepBack};
      StepObserve:   w = '{OpObserve, CondNever,    StepFetch};
      StepTestGap:   w = '{OpNone,    CondGap,      StepGap};
      StepTolMul:    w = '{OpTolMul,  CondNever,    StepFetch};
      StepTolSet:    w = '{OpTolSet,  CondNever,    StepFetch};
      StepFlags:     w = '{OpFlags,   CondLate,     StepDivInit};
      StepEarly:     w = '{OpEarly,   CondAlways,   StepEmit};
      StepDivInit:   w = '{OpDivInit, CondNever,    StepFetch};
      StepDivStep:   w = '{OpDivStep, CondDivMore,  StepDivStep};
      StepLateSet:   w = '{OpLateSet, CondAlways,   StepEmit};
      StepFirst:     w = '{OpFirst,   CondAlways,   StepEmit};
      StepBack:      w = '{OpBack,    CondAlways,   StepEmit};
      StepGap:       w = '{OpGap,     CondNever,    StepFetch};
      StepEmit:      w = '{OpEmit,    CondOutBusy,  StepEmit};
      default:       w = '{OpNone,    CondAlways,   StepFetch};
    endcase
    return w;
  endfunction

endpackage

// File: design/pdp_rem_unit.sv
`timescale 1ns / 1ps

// Restoring remainder, one dividend bit per step, MSB first.
module pdp_rem_unit #(
  parameter int unsigned TIME_WIDTH = pdp_pkg::TimeWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pdp_pkg::div_ctrl_t            ctrl_i,
  input  logic [TIME_WIDTH-1:0]         dividend_i,
  input  logic [pdp_pkg::IvlWidth-1:0]  divisor_i,
  output logic [pdp_pkg::IvlWidth-1:0]  rem_o,
  output logic                          more_o
);

  localparam int unsigned CntWidth = $clog2(TIME_WIDTH + 1);
  localparam int unsigned IW       = pdp_pkg::IvlWidth;

  logic [TIME_WIDTH-1:0] dvd_q, dvd_d;
  logic [IW-1:0]         rem_q, rem_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [IW:0]           trial;

  assign trial = {rem_q, dvd_q[TIME_WIDTH-1]};

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (ctrl_i.init) begin
      dvd_d = dividend_i;
      rem_d = '0;
      cnt_d = CntWidth'(TIME_WIDTH);
    end else if (ctrl_i.step) begin
      dvd_d = {dvd_q[TIME_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CntWidth'(1);
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = IW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = IW'(trial);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign rem_o  = rem_q;
  assign more_o = (cnt_q != CntWidth'(1));

endmodule

// File: design/present_deadline_pacer.sv
`timescale 1ns / 1ps

// Present pacer: each transfer on s_axis carries one present timestamp (ns) and yields
// exactly one result on m_axis with the delay to wait, the observed interval, a rebase
// flag and two limiter flags. A small microcode sequencer walks each item through a
// plain datapath. Separate paths serve inactive pacing, a first present, time going
// backwards, a long gap and a deadline still ahead; when a deadline was missed the
// path runs the remainder unit one dividend bit per cycle. The emit step waits while
// the previous result still sits in the output register. A new item is taken once the
// sequencer is back at its fetch step, in the cycle after the emit; a result that
// waits for m_axis_tready does not block the next item's work until that item reaches
// its own emit step. Writing target_interval_ns (byte address 0) clears the pacing
// state; zero disables pacing.
module present_deadline_pacer #(
  parameter int unsigned TIME_WIDTH = pdp_pkg::TimeWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pdp_pkg::CfgAddrWidth-1:0]   paddr,
  input  logic [pdp_pkg::CfgDataWidth-1:0]   pwdata,
  output logic [pdp_pkg::CfgDataWidth-1:0]   prdata,
  output logic                               pready,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [pdp_pkg::NowWidth-1:0]       s_axis_tdata,   // [63:0] now_ns
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [29:0] interval_echo_ns, [93:30] delay_ns, [157:94] observed_interval_ns,
  // [158] rebased, [159] limiter_satisfied, [160] limiter_stricter, [167:161] zero
  output logic [pdp_pkg::OutDataWidth-1:0]   m_axis_tdata
);

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned IW = pdp_pkg::IvlWidth;
  localparam int unsigned TolW = pdp_pkg::TolWidth;
  localparam int unsigned PW = pdp_pkg::ProdWidth;
  localparam int unsigned NW = pdp_pkg::NowWidth;
  localparam int unsigned OutPad = pdp_pkg::OutDataWidth - (IW + 2 * NW + 3);

  // configuration
  logic [IW-1:0] ivl_q, ivl_d;
  logic          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite &&
                  (paddr[pdp_pkg::CfgAddrWidth-1:2] == pdp_pkg::RegTargetInterval);
  assign prdata = (paddr[pdp_pkg::CfgAddrWidth-1:2] == pdp_pkg::RegTargetInterval) ?
                  pdp_pkg::CfgDataWidth'(ivl_q) : '0;

  // sequencer
  logic [pdp_pkg::StepWidth-1:0] pc_q, pc_d;
  pdp_pkg::ucode_t               uw;
  logic                          cond_hit;

  // pacing state
  logic          has_q, has_d;
  logic [TW-1:0] last_q, last_d;
  logic [TW-1:0] dl_q, dl_d;
  logic [TW-1:0] sched_q, sched_d;

  // working registers
  logic [TW-1:0]   now_q, now_d;
  logic [TW-1:0]   obs_q, obs_d;
  logic [TW-1:0]   delay_q, delay_d;
  logic [TW-1:0]   unas_q, unas_d;
  logic [PW-1:0]   prod_q, prod_d;
  logic [TolW-1:0] tol_q, tol_d;
  logic            reb_q, reb_d;
  logic            sat_q, sat_d;
  logic            strict_q, strict_d;

  // result register
  logic                            out_valid_q, out_valid_d;
  logic [pdp_pkg::OutDataWidth-1:0] out_data_q, out_data_d;
  logic                            out_free;

  // remainder unit
  pdp_pkg::div_ctrl_t div_ctrl;
  logic [IW-1:0]      rem;
  logic               div_more;

  logic [TW-1:0]    ivl_t;
  logic [TW:0]      unas_tol, ivl_tol;
  logic [TolW-1:0]  tol_div;

  assign ivl_t    = TW'(ivl_q);
  assign out_free = !out_valid_q || m_axis_tready;
  assign unas_tol = {1'b0, unas_q} + (TW + 1)'(tol_q);
  assign ivl_tol  = (TW + 1)'(ivl_q) + (TW + 1)'(tol_q);
  assign tol_div  = prod_q[PW-1:pdp_pkg::RecipShift];

  assign s_axis_tready = (pc_q == pdp_pkg::StepFetch);
  assign uw            = pdp_pkg::ucode_rom(pc_q);

  always_comb begin
    case (uw.cond)
      pdp_pkg::CondNever:    cond_hit = 1'b0;
      pdp_pkg::CondAlways:   cond_hit = 1'b1;
      pdp_pkg::CondNoInput:  cond_hit = !s_axis_tvalid;
      pdp_pkg::CondIvlZero:  cond_hit = (ivl_q == '0);
      pdp_pkg::CondFirst:    cond_hit = !has_q;
      pdp_pkg::CondBackward: cond_hit = (now_q < last_q);
      pdp_pkg::CondGap:      cond_hit = (obs_q > (ivl_t << pdp_pkg::GapShift));
      pdp_pkg::CondLate:     cond_hit = (now_q >= dl_q);
      pdp_pkg::CondDivMore:  cond_hit = div_more;
      pdp_pkg::CondOutBusy:  cond_hit = !out_free;
      default:               cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_hit) begin
      pc_d = uw.target;
    end else if (pc_q == pdp_pkg::StepLast) begin
      pc_d = pdp_pkg::StepFetch;
    end else begin
      pc_d = pc_q + pdp_pkg::StepWidth'(1);
    end
  end

  // datapath
  always_comb begin
    ivl_d       = ivl_q;
    has_d       = has_q;
    last_d      = last_q;
    dl_d        = dl_q;
    sched_d     = sched_q;
    now_d       = now_q;
    obs_d       = obs_q;
    delay_d     = delay_q;
    unas_d      = unas_q;
    prod_d      = prod_q;
    tol_d       = tol_q;
    reb_d       = reb_q;
    sat_d       = sat_q;
    strict_d    = strict_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    div_ctrl    = '0;

    case (uw.op)
      pdp_pkg::OpLoadNow: begin
        if (s_axis_tvalid) begin
          now_d = s_axis_tdata[TW-1:0];
        end
      end
      pdp_pkg::OpClear: begin
        obs_d    = '0;
        delay_d  = '0;
        reb_d    = 1'b0;
        sat_d    = 1'b0;
        strict_d = 1'b0;
      end
      pdp_pkg::OpObserve: begin
        obs_d  = now_q - last_q;
        last_d = now_q;
      end
      pdp_pkg::OpTolMul: begin
        prod_d = PW'(pdp_pkg::TolXWidth'(ivl_q) * pdp_pkg::TolXWidth'(pdp_pkg::TolPct)) *
                 PW'(pdp_pkg::TolRecip);
      end
      pdp_pkg::OpTolSet: begin
        tol_d  = (tol_div < pdp_pkg::TolFloor) ? pdp_pkg::TolFloor : tol_div;
        unas_d = (obs_q > sched_q) ? obs_q - sched_q : '0;
      end
      pdp_pkg::OpFlags: begin
        sat_d    = (unas_tol >= (TW + 1)'(ivl_q));
        strict_d = ({1'b0, unas_q} > ivl_tol);
      end
      pdp_pkg::OpEarly: begin
        delay_d = dl_q - now_q;
        sched_d = dl_q - now_q;
        dl_d    = dl_q + ivl_t;
      end
      pdp_pkg::OpDivInit: begin
        div_ctrl.init = 1'b1;
      end
      pdp_pkg::OpDivStep: begin
        div_ctrl.step = 1'b1;
      end
      pdp_pkg::OpLateSet: begin
        // deadline + (q + 1) * ivl == now - rem + ivl
        dl_d    = now_q - TW'(rem) + ivl_t;
        sched_d = '0;
      end
      pdp_pkg::OpFirst: begin
        has_d   = 1'b1;
        last_d  = now_q;
        dl_d    = now_q + ivl_t + ivl_t;
        delay_d = ivl_t;
        sched_d = ivl_t;
        reb_d   = 1'b1;
      end
      pdp_pkg::OpBack: begin
        last_d  = now_q;
        dl_d    = now_q + ivl_t;
        sched_d = '0;
        reb_d   = 1'b1;
      end
      pdp_pkg::OpGap: begin
        dl_d    = now_q + ivl_t;
        sched_d = '0;
        reb_d   = 1'b1;
      end
      pdp_pkg::OpEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {OutPad'(0), strict_q, sat_q, reb_q,
                         NW'(obs_q), NW'(delay_q), ivl_q};
        end
      end
      default: begin
      end
    endcase

    // configuration is to arrive only while idle; the block itself does not enforce it
    if (cfg_we) begin
      ivl_d   = pwdata[IW-1:0];
      has_d   = 1'b0;
      last_d  = '0;
      dl_d    = '0;
      sched_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= pdp_pkg::StepFetch;
      ivl_q       <= '0;
      has_q       <= 1'b0;
      last_q      <= '0;
      dl_q        <= '0;
      sched_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      ivl_q       <= ivl_d;
      has_q       <= has_d;
      last_q      <= last_d;
      dl_q        <= dl_d;
      sched_q     <= sched_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    obs_q      <= obs_d;
    delay_q    <= delay_d;
    unas_q     <= unas_d;
    prod_q     <= prod_d;
    tol_q      <= tol_d;
    reb_q      <= reb_d;
    sat_q      <= sat_d;
    strict_q   <= strict_d;
    out_data_q <= out_data_d;
  end

  pdp_rem_unit #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (now_q - dl_q),
    .divisor_i  (ivl_q),
    .rem_o      (rem),
    .more_o     (div_more)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // an accepted transfer moves the sequencer off the fetch step
  a_accept_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> pc_q == pdp_pkg::StepCheck)
    else $error("sequencer did not advance after input transfer");

  // an emit step with a free output register presents a result next cycle
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == pdp_pkg::StepEmit && out_free |=> m_axis_tvalid && pc_q == pdp_pkg::StepFetch)
    else $error("result not presented after emit step");

  // remainder loop only runs with a nonzero interval
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == pdp_pkg::StepDivStep |-> ivl_q != '0)
    else $error("remainder step with zero interval");

  // remainder is reduced below the interval when it is consumed
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == pdp_pkg::StepLateSet |-> rem < ivl_q)
    else $error("remainder not below interval");

endmodule
